FILE: design/dtdn_pkg.sv
// ----------------------------------------------------------------------------
// dtdn_pkg: shared types and constants
// Status codes, the parse record passed from the front end to the back end,
// and the month offset table of the day count.
// ----------------------------------------------------------------------------
`default_nettype none

package dtdn_pkg;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FORMAT     = 3'd1;
  localparam logic [2:0] ST_DIGIT      = 3'd2;
  localparam logic [2:0] ST_MONTH      = 3'd3;
  localparam logic [2:0] ST_YEAR_EARLY = 3'd4;
  localparam logic [2:0] ST_DAY        = 3'd5;

  localparam logic [7:0] CHAR_TERM  = 8'h00;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [3:0] POS_DASH1  = 4'd2;
  localparam logic [3:0] POS_DASH2  = 4'd5;
  localparam logic [3:0] POS_LEN    = 4'd10;
  localparam logic [3:0] POS_SAT    = 4'd11;

  localparam logic [13:0] MIN_YEAR_RESET = 14'd1900;

  // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT for any 14-bit y
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  typedef struct packed {
    logic        fmt_bad;
    logic        dig_bad;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [13:0] year;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  // (153 * (m - 3) + 2) / 5 with January and February as months 13 and 14
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/dtdn_char_if.sv
// ----------------------------------------------------------------------------
// dtdn_char_if: character input channel
// Valid/ready channel carrying one byte of the date string per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtdn_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;

  modport source (output valid, output text_char, input ready);
  modport sink   (input valid, input text_char, output ready);
endinterface

`default_nettype wire

FILE: design/dtdn_result_if.sv
// ----------------------------------------------------------------------------
// dtdn_result_if: result output channel
// Valid/ready channel carrying one parsed date and its day number per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtdn_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [6:0]  day_value;
  logic [6:0]  month_value;
  logic [13:0] year_value;
  logic [21:0] day_number;

  modport source (output valid, output status, output day_value, output month_value,
                  output year_value, output day_number, input ready);
  modport sink   (input valid, input status, input day_value, input month_value,
                  input year_value, input day_number, output ready);
endinterface

`default_nettype wire

FILE: design/dtdn_front.sv
// ----------------------------------------------------------------------------
// dtdn_front: character parser
// Tracks the position, checks dashes and digits, accumulates the fields and
// pushes one parse record on each terminator.
// ----------------------------------------------------------------------------
`default_nettype none

module dtdn_front (
  input  wire logic           clk,
  input  wire logic           rst,
  dtdn_char_if.sink           in_ch,
  input  wire logic           queue_full,
  output dtdn_pkg::push_t     push
);
  import dtdn_pkg::*;

  logic [3:0]  char_position;
  logic [6:0]  day_accum;
  logic [6:0]  month_accum;
  logic [13:0] year_accum;
  logic        format_error;
  logic        digit_error;

  logic [3:0]  char_position_next;
  logic [6:0]  day_accum_next;
  logic [6:0]  month_accum_next;
  logic [13:0] year_accum_next;
  logic        format_error_next;
  logic        digit_error_next;

  logic        accept;
  logic        is_term;
  logic [3:0]  digit;

  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_term     = (in_ch.text_char == CHAR_TERM);
  assign digit       = 4'(in_ch.text_char - CHAR_ZERO);

  always_comb begin
    char_position_next = char_position;
    day_accum_next     = day_accum;
    month_accum_next   = month_accum;
    year_accum_next    = year_accum;
    format_error_next  = format_error;
    digit_error_next   = digit_error;
    if (is_term) begin
      char_position_next = '0;
      day_accum_next     = '0;
      month_accum_next   = '0;
      year_accum_next    = '0;
      format_error_next  = 1'b0;
      digit_error_next   = 1'b0;
    end else begin
      if (char_position >= POS_LEN) begin
        format_error_next = 1'b1;
      end else if (char_position == POS_DASH1 || char_position == POS_DASH2) begin
        if (in_ch.text_char != CHAR_DASH) format_error_next = 1'b1;
      end else if (in_ch.text_char < CHAR_ZERO || in_ch.text_char > CHAR_NINE) begin
        digit_error_next = 1'b1;
      end else if (char_position < POS_DASH1) begin
        day_accum_next = 7'((11'(day_accum) * 11'd10) + 11'(digit));
      end else if (char_position < POS_DASH2) begin
        month_accum_next = 7'((11'(month_accum) * 11'd10) + 11'(digit));
      end else begin
        year_accum_next = 14'((18'(year_accum) * 18'd10) + 18'(digit));
      end
      if (char_position < POS_SAT) char_position_next = char_position + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      day_accum     <= '0;
      month_accum   <= '0;
      year_accum    <= '0;
      format_error  <= 1'b0;
      digit_error   <= 1'b0;
    end else if (accept) begin
      char_position <= char_position_next;
      day_accum     <= day_accum_next;
      month_accum   <= month_accum_next;
      year_accum    <= year_accum_next;
      format_error  <= format_error_next;
      digit_error   <= digit_error_next;
    end
  end

  always_comb begin
    push.valid         = accept && is_term;
    push.entry.fmt_bad = (char_position != POS_LEN) || format_error;
    push.entry.dig_bad = digit_error;
    push.entry.day     = day_accum;
    push.entry.month   = month_accum;
    push.entry.year    = year_accum;
  end

endmodule

`default_nettype wire

FILE: design/dtdn_queue.sv
// ----------------------------------------------------------------------------
// dtdn_queue: parse record queue
// Two-entry FIFO that decouples the parser from the day-count pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module dtdn_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dtdn_pkg::push_t push,
  input  wire logic            pop,
  output logic                 full,
  output logic                 not_empty,
  output dtdn_pkg::entry_t     head
);
  import dtdn_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push.entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/dtdn_back.sv
// ----------------------------------------------------------------------------
// dtdn_back: validation and day-count pipeline
// Three stages: divide by 100, range checks and leap year, day-count sum.
// The last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtdn_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire dtdn_pkg::entry_t head,
  output logic                  pop,
  input  wire logic [13:0]      min_year,
  dtdn_result_if.source         out_ch
);
  import dtdn_pkg::*;

  function automatic logic [4:0] days_in_month(input logic [6:0] m, input logic leap);
    logic [4:0] r;
    case (m) inside
      7'd4, 7'd6, 7'd9, 7'd11: r = 5'd30;
      7'd2:                    r = leap ? 5'd29 : 5'd28;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

  logic        advance;

  // stage 1
  logic        s1_valid;
  entry_t      s1_entry;
  logic [7:0]  s1_y100;
  logic        s1_year_low;
  logic        s1_month_bad;
  logic [26:0] y_prod;

  // stage 2
  logic        s2_valid;
  logic [2:0]  s2_status;
  logic [6:0]  s2_day;
  logic [6:0]  s2_month;
  logic [13:0] s2_year;
  logic [13:0] s2_ya;
  logic [7:0]  s2_ya100;
  logic        s2_zero;

  logic [13:0] r100;
  logic        leap;
  logic        early;
  logic [2:0]  status_c;

  // stage 3
  logic        s3_valid;
  logic [21:0] sum;

  assign advance = !s3_valid || out_ch.ready;
  assign pop     = advance && head_valid;
  assign y_prod  = 27'(head.year) * 27'(DIV100_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_entry     <= head;
      s1_y100      <= y_prod[DIV100_SHIFT +: 8];
      s1_year_low  <= (head.year < min_year);
      s1_month_bad <= (head.month == 7'd0) || (head.month > 7'd12);
    end
  end

  always_comb begin
    r100  = s1_entry.year - 14'(s1_y100 * 14'd100);
    leap  = (r100 == 14'd0) ? (s1_y100[1:0] == 2'd0) : (s1_entry.year[1:0] == 2'd0);
    early = (s1_entry.month <= 7'd2);
    if (s1_entry.fmt_bad) begin
      status_c = ST_FORMAT;
    end else if (s1_entry.dig_bad) begin
      status_c = ST_DIGIT;
    end else if (s1_month_bad) begin
      status_c = ST_MONTH;
    end else if (s1_year_low) begin
      status_c = ST_YEAR_EARLY;
    end else if (s1_entry.day == 7'd0 ||
                 s1_entry.day > 7'(days_in_month(s1_entry.month, leap))) begin
      status_c = ST_DAY;
    end else begin
      status_c = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_status <= status_c;
      if (status_c == ST_FORMAT || status_c == ST_DIGIT) begin
        s2_day   <= '0;
        s2_month <= '0;
        s2_year  <= '0;
      end else begin
        s2_day   <= s1_entry.day;
        s2_month <= s1_entry.month;
        s2_year  <= s1_entry.year;
      end
      s2_ya    <= early ? s1_entry.year - 14'd1 : s1_entry.year;
      s2_ya100 <= (early && r100 == 14'd0) ? s1_y100 - 8'd1 : s1_y100;
      s2_zero  <= early && (s1_entry.year == 14'd0);
    end
  end

  assign sum = 22'(s2_ya) * 22'd365 + 22'(s2_ya >> 2) - 22'(s2_ya100)
             + 22'(s2_ya100 >> 2) + 22'(month_offset(s2_month[3:0])) + 22'(s2_day);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.status      <= s2_status;
      out_ch.day_value   <= s2_day;
      out_ch.month_value <= s2_month;
      out_ch.year_value  <= s2_year;
      out_ch.day_number  <= (s2_status == ST_OK && !s2_zero) ? sum : 22'd0;
    end
  end

  assign out_ch.valid = s3_valid;

endmodule

`default_nettype wire

FILE: design/date_text_to_day_number_core.sv
// Path: a terminator beat is written to the queue when it is accepted, then goes
//   through the divide stage, check stage and sum stage into the output register.
// Throughput: one character per cycle; the parser takes a beat every cycle while
//   the two-entry record queue has room, set by the three-stage back pipeline.
// Reset: synchronous, active high; clears the parser, the queue and all stage
//   valids, and loads min_year with 1900.
// ----------------------------------------------------------------------------
// date_text_to_day_number_core: DD-MM-YYYY text to Gregorian day number
// Parses a zero-terminated date string one byte per beat and returns a status,
// the parsed fields and the serial day count on each terminator.
// ----------------------------------------------------------------------------
`default_nettype none

module date_text_to_day_number_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [13:0] cfg_wr_data,
  dtdn_char_if.sink        in_ch,
  dtdn_result_if.source    out_ch
);
  import dtdn_pkg::*;

  // Earliest accepted year; the user must write it only while the block is idle, which the block does not enforce.
  logic [13:0] min_year;

  push_t  push;
  entry_t head;
  logic   queue_full;
  logic   queue_not_empty;
  logic   pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= MIN_YEAR_RESET;
    end else if (cfg_wr_en) begin
      min_year <= cfg_wr_data;
    end
  end

  // Front: take one character per beat, hold position and digit accumulators,
  // push a record on the terminator and clear for the next string.
  dtdn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .queue_full (queue_full),
    .push       (push)
  );

  // Queue: hold up to two finished records so the parser keeps running while
  // the output side stalls, until both slots are full.
  dtdn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (head)
  );

  // Back: classify the record, then compute the day count. The whole pipe
  // advances whenever the output register is empty or being drained.
  dtdn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (queue_not_empty),
    .head       (head),
    .pop        (pop),
    .min_year   (min_year),
    .out_ch     (out_ch)
  );

  // A rejected date never carries a day count.
  a_bad_no_count: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.status != ST_OK) |-> (out_ch.day_number == 22'd0))
    else $error("day_number nonzero on a rejected date");

  // Format and digit failures report no parsed fields.
  a_malformed_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.status == ST_FORMAT || out_ch.status == ST_DIGIT)
    |-> (out_ch.day_value == 7'd0 && out_ch.month_value == 7'd0 &&
         out_ch.year_value == 14'd0))
    else $error("fields not cleared on a malformed date");

  // An accepted date has a month in range, a year at or above the limit and a nonzero day.
  a_ok_in_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.status == ST_OK)
    |-> (out_ch.month_value != 7'd0 && out_ch.month_value <= 7'd12 &&
         out_ch.year_value >= min_year && out_ch.day_value != 7'd0))
    else $error("ok status on an out-of-range date");

endmodule

`default_nettype wire

FILE: tb/tb_date_text_to_day_number_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_date_text_to_day_number_core: self-checking bench for the date parser
// Streams DD-MM-YYYY strings into the character channel and predicts each
// terminator's result in step with the accepted beats. Every result beat is
// compared field by field against the oldest prediction while both channels
// idle and stall at random.
// ----------------------------------------------------------------------------

module tb_date_text_to_day_number_core;
  import dtdn_pkg::*;

  // Quiet cycles allowed before the run is declared hung
  localparam int STALL_LIMIT  = 2000;
  // Cycles to hold after the last result before touching min_year or ending
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 1000;

  typedef struct {
    logic [2:0]  status;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [13:0] year;
    logic [21:0] day_number;
  } date_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [13:0] cfg_wr_data;

  dtdn_char_if   char_ch ();
  dtdn_result_if res_ch ();

  date_text_to_day_number_core u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (char_ch),
    .out_ch      (res_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Parser state as the bench tracks it, plus the register copy
  logic [3:0]  pos_cnt;
  logic [6:0]  acc_day;
  logic [6:0]  acc_month;
  logic [13:0] acc_year;
  logic        fmt_bad;
  logic        dig_bad;
  logic [13:0] min_year_cfg;

  date_result_t pending_dates[$];
  logic [7:0]   text_buf [0:15];

  int burst_left     = 0;
  int bytes_sent     = 0;
  int dates_sent     = 0;
  int dates_checked  = 0;
  int error_count    = 0;
  int settings_used  = 0;
  int idle_cycles    = 0;
  int status_seen [0:7];

  // --------------------------------------------------------------------------
  // Calendar arithmetic
  // --------------------------------------------------------------------------
  function automatic bit is_leap(input int unsigned y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4) == 0;
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    if (m == 2) return is_leap(y) ? 29 : 28;
    return 31;
  endfunction

  // Serial day count; January and February belong to the previous year
  function automatic logic [21:0] day_count(input int unsigned d, input int unsigned m,
                                            input int unsigned y);
    int unsigned s;
    if (m <= 2) begin
      // year zero would go negative: clamp to zero
      if (y == 0) return 22'd0;
      y = y - 1;
      m = m + 12;
    end
    s = 365 * y + y / 4 - y / 100 + y / 400 + (153 * (m - 3) + 2) / 5 + d;
    return s[21:0];
  endfunction

  task automatic reset_parse_state();
    pos_cnt   = '0;
    acc_day   = '0;
    acc_month = '0;
    acc_year  = '0;
    fmt_bad   = 1'b0;
    dig_bad   = 1'b0;
  endtask

  // Advance the tracked parser by one accepted beat; queue a prediction on
  // the terminator.
  task automatic parse_date_char(input logic [7:0] c);
    date_result_t r;
    logic [7:0]   v;
    if (c != CHAR_TERM) begin
      v = c - CHAR_ZERO;
      if (pos_cnt >= POS_LEN) begin
        fmt_bad = 1'b1;
      end else if (pos_cnt == POS_DASH1 || pos_cnt == POS_DASH2) begin
        if (c != CHAR_DASH) fmt_bad = 1'b1;
      end else if (c < CHAR_ZERO || c > CHAR_NINE) begin
        dig_bad = 1'b1;
      end else if (pos_cnt < POS_DASH1) begin
        acc_day = acc_day * 7'd10 + v[6:0];
      end else if (pos_cnt < POS_DASH2) begin
        acc_month = acc_month * 7'd10 + v[6:0];
      end else begin
        acc_year = acc_year * 14'd10 + {6'd0, v};
      end
      // position saturates once the string is known to be too long
      if (pos_cnt < POS_SAT) pos_cnt = pos_cnt + 4'd1;
    end else begin
      r.status     = ST_OK;
      r.day        = acc_day;
      r.month      = acc_month;
      r.year       = acc_year;
      r.day_number = '0;
      if (pos_cnt != POS_LEN || fmt_bad) begin
        r.status = ST_FORMAT;
        r.day    = '0;
        r.month  = '0;
        r.year   = '0;
      end else if (dig_bad) begin
        // one error bit only: well-formed fields are dropped as well
        r.status = ST_DIGIT;
        r.day    = '0;
        r.month  = '0;
        r.year   = '0;
      end else if (acc_month < 1 || acc_month > 12) begin
        r.status = ST_MONTH;
      end else if (acc_year < min_year_cfg) begin
        r.status = ST_YEAR_EARLY;
      end else if (acc_day < 1 || acc_day > month_length(acc_month, acc_year)) begin
        r.status = ST_DAY;
      end else begin
        r.day_number = day_count(acc_day, acc_month, acc_year);
      end
      pending_dates.push_back(r);
      dates_sent++;
      reset_parse_state();
    end
  endtask

  // --------------------------------------------------------------------------
  // Character sender
  // Every call starts in the time step of a rising edge. Valid stays high
  // across a burst; a gap drops it for a random number of cycles.
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        char_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // mostly short bursts, now and then a long run with no idling
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    char_ch.valid     <= 1'b1;
    char_ch.text_char <= c;
    @(posedge clk);
    while (!char_ch.ready) @(posedge clk);
    parse_date_char(c);
    bytes_sent++;
  endtask

  task automatic send_buf(input int n);
    int i;
    for (i = 0; i < n; i++) send_char(text_buf[i]);
    send_char(CHAR_TERM);
  endtask

  task automatic send_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CHAR_TERM);
  endtask

  task automatic fill_date(input int unsigned d, input int unsigned m, input int unsigned y);
    text_buf[0] = CHAR_ZERO + 8'(d / 10);
    text_buf[1] = CHAR_ZERO + 8'(d % 10);
    text_buf[2] = CHAR_DASH;
    text_buf[3] = CHAR_ZERO + 8'(m / 10);
    text_buf[4] = CHAR_ZERO + 8'(m % 10);
    text_buf[5] = CHAR_DASH;
    text_buf[6] = CHAR_ZERO + 8'(y / 1000);
    text_buf[7] = CHAR_ZERO + 8'((y / 100) % 10);
    text_buf[8] = CHAR_ZERO + 8'((y / 10) % 10);
    text_buf[9] = CHAR_ZERO + 8'(y % 10);
  endtask

  // Drop valid, wait out every outstanding result, then hold for the pipe
  task automatic drain();
    char_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_min_year(input logic [13:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    min_year_cfg = v;
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Result checker and receiver stall pattern
  // The receiver switches among modes: always ready, coin flip, one in four,
  // and random stall runs.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [21:0] exp_v,
                             input logic [21:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, got_v);
      error_count++;
    end
  endtask

  initial begin : result_checker
    date_result_t exp_r;
    int           rx_mode;
    int           rx_mode_left;
    int           stall_run;
    int           rx_cycle;
    logic         rdy;
    rx_mode      = 0;
    rx_mode_left = 0;
    stall_run    = 0;
    rx_cycle     = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        if (pending_dates.size() == 0) begin
          $display("%0t: result beat with nothing expected, status %0d day_number %0d",
                   $realtime, res_ch.status, res_ch.day_number);
          error_count++;
        end else begin
          exp_r = pending_dates.pop_front();
          check_field("status",      exp_r.status,     res_ch.status);
          check_field("day_value",   exp_r.day,        res_ch.day_value);
          check_field("month_value", exp_r.month,      res_ch.month_value);
          check_field("year_value",  exp_r.year,       res_ch.year_value);
          check_field("day_number",  exp_r.day_number, res_ch.day_number);
          status_seen[exp_r.status]++;
          dates_checked++;
        end
      end
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 80);
      end
      rx_mode_left--;
      rx_cycle++;
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = (rx_cycle % 4) == 0;
        default: begin
          if (stall_run > 0) begin
            stall_run--;
            rdy = 1'b0;
          end else begin
            rdy = 1'b1;
            if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 12);
          end
        end
      endcase
      res_ch.ready <= rdy;
    end
  end

  // Watchdog: end the run if neither channel moves a beat for too long
  always @(posedge clk) begin
    if ((char_ch.valid && char_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
               $realtime, STALL_LIMIT, pending_dates.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset value of min_year is 1900: check both sides of it and the top date
  task automatic test_default_year_bounds();
    send_str("01-01-1900");
    send_str("31-12-1899");
    send_str("31-12-9999");
  endtask

  // All-zero and all-nine fields, day just outside the month
  task automatic test_field_extremes();
    send_str("00-00-0000");
    send_str("99-99-9999");
    send_str("00-01-2000");
    send_str("32-01-2000");
  endtask

  // Leap rules for 4, 100 and 400, and the 30-day months
  task automatic test_calendar_rules();
    send_str("29-02-2000");
    send_str("29-02-1900");
    send_str("29-02-2024");
    send_str("29-02-2023");
    send_str("31-04-2023");
    send_str("30-06-2023");
  endtask

  // Length, dash and digit errors, format winning over digits, saturation
  task automatic test_malformed_text();
    send_str("");
    send_str("1-01-2000");
    send_str("01/01/2000");
    send_str("/1-01-2:00");
    send_str("0a/01-2000");
    send_str("01-01-2000-01-01");
    // bytes with the top bit set at digit positions
    fill_date(1, 1, 2000);
    text_buf[3] = 8'hFF;
    text_buf[9] = 8'h80;
    send_buf(10);
  endtask

  // min_year at both ends: year zero in January clamps the count to zero
  task automatic test_min_year_extremes();
    set_min_year(14'd0);
    send_str("01-01-0000");
    send_str("29-02-0000");
    send_str("01-03-0000");
    send_str("00-13-0000");
    set_min_year(14'd9999);
    send_str("31-12-9999");
    send_str("31-12-9998");
  endtask

  // Mostly well-formed dates with random content around the interesting
  // years; the rest are corrupted, cut, stretched or pure noise.
  task automatic send_random_date();
    int unsigned d, m, y, lo, hi, k, n, r;
    case ($urandom_range(0, 4))
      0: y = $urandom_range(0, 9999);
      1: begin
        lo = (min_year_cfg > 2) ? min_year_cfg - 2 : 0;
        hi = (lo + 4 > 9999) ? 9999 : lo + 4;
        y  = $urandom_range(lo, hi);
      end
      2: y = $urandom_range(0, 99) * 100;
      3: y = $urandom_range(0, 2499) * 4;
      default: y = $urandom_range(min_year_cfg, 9999);
    endcase
    if ($urandom_range(0, 9) == 0) begin
      m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
    end else begin
      m = $urandom_range(1, 12);
    end
    k = month_length(m, y);
    r = $urandom_range(0, 9);
    if (r < 7)       d = $urandom_range(1, k);
    else if (r == 7) d = k + $urandom_range(0, 1);
    else if (r == 8) d = $urandom_range(29, 31);
    else             d = $urandom_range(0, 1) ? 0 : $urandom_range(32, 99);
    fill_date(d, m, y);
    n = 10;
    if ($urandom_range(0, 99) >= 82) begin
      case ($urandom_range(0, 3))
        0: text_buf[$urandom_range(0, 9)] = 8'($urandom_range(1, 255));
        1: n = $urandom_range(0, 9);
        2: begin
          n = $urandom_range(11, 15);
          for (k = 10; k < n; k++) text_buf[k] = 8'($urandom_range(1, 255));
        end
        default: begin
          n = $urandom_range(0, 15);
          for (k = 0; k < n; k++) text_buf[k] = 8'($urandom_range(1, 255));
        end
      endcase
    end
    send_buf(n);
  endtask

  task automatic test_random_dates();
    int start_bytes;
    int phase_left;
    start_bytes = bytes_sent;
    phase_left  = 0;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 4))
          0: set_min_year(14'd0);
          1: set_min_year(14'd9999);
          2: set_min_year(MIN_YEAR_RESET);
          3: set_min_year(14'($urandom_range(0, 9999)));
          default: set_min_year(14'($urandom_range(1500, 2500)));
        endcase
        phase_left = $urandom_range(10, 30);
      end
      phase_left--;
      send_random_date();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    char_ch.valid     = 1'b0;
    char_ch.text_char = '0;
    min_year_cfg      = MIN_YEAR_RESET;
    reset_parse_state();
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_default_year_bounds();
    test_field_extremes();
    test_calendar_rules();
    test_malformed_text();
    test_min_year_extremes();
    test_random_dates();
    drain();

    $display("Covered %0d date strings in %0d bytes over %0d min_year settings, %0d checked",
             dates_sent, bytes_sent, settings_used, dates_checked);
    $display("Status mix: ok %0d, format %0d, digit %0d, month %0d, year %0d, day %0d",
             status_seen[ST_OK], status_seen[ST_FORMAT], status_seen[ST_DIGIT],
             status_seen[ST_MONTH], status_seen[ST_YEAR_EARLY], status_seen[ST_DAY]);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
